// ===== sv/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types for the frame deframer: parse phases and the queued result item.
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES = 4'd4;

    // one result item as classified by the front end, unmasking done later
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        logic       fin;
        logic       empty;
        logic       last;
    } cmd_t;

endpackage

// ===== sv/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// wsd_parser
// Front end: walks the frame header, holds length and mask key, and pushes one
// classified item per payload byte (or one for an empty frame) to the queue.
// ----------------------------------------------------------------------------
module wsd_parser
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] stream_byte,
    output logic       push,
    output cmd_t       push_cmd
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic        masked_reg, masked_next;
    logic [63:0] remain_reg, remain_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  index_reg, index_next;

    logic [6:0]  len7;
    logic [63:0] ext_len;
    logic [3:0]  count_dec;
    logic [7:0]  key_byte;
    logic        data_last;

    assign len7      = stream_byte[6:0];
    assign ext_len   = {remain_reg[55:0], stream_byte};
    assign count_dec = count_reg - 4'd1;
    assign data_last = (remain_reg == 64'd1);

    always_comb
    begin
        unique case (index_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
            default: key_byte = key_reg[31:24];
        endcase
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        remain_next = remain_reg;
        key_next    = key_reg;
        index_next  = index_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR1:
                begin
                    masked_next = stream_byte[7];
                    if (len7 == LEN_EXT16)
                    begin
                        remain_next = '0;
                        phase_next  = PH_EXT;
                        count_next  = EXT16_BYTES;
                    end
                    else if (len7 == LEN_EXT64)
                    begin
                        remain_next = '0;
                        phase_next  = PH_EXT;
                        count_next  = EXT64_BYTES;
                    end
                    else
                    begin
                        remain_next = {57'd0, len7};
                        if (stream_byte[7])
                        begin
                            phase_next = PH_KEY;
                            count_next = KEY_BYTES;
                            key_next   = '0;
                        end
                        else
                        begin
                            index_next = '0;
                            phase_next = (len7 == 7'd0) ? PH_HDR0 : PH_DATA;
                        end
                    end
                end
                PH_EXT:
                begin
                    remain_next = ext_len;
                    count_next  = count_dec;
                    if (count_dec == 4'd0)
                    begin
                        if (masked_reg)
                        begin
                            phase_next = PH_KEY;
                            count_next = KEY_BYTES;
                            key_next   = '0;
                        end
                        else
                        begin
                            index_next = '0;
                            phase_next = (ext_len == 64'd0) ? PH_HDR0 : PH_DATA;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next   = {key_reg[23:0], stream_byte};
                    count_next = count_dec;
                    if (count_dec == 4'd0)
                    begin
                        index_next = '0;
                        phase_next = (remain_reg == 64'd0) ? PH_HDR0 : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    index_next  = index_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    if (data_last)
                        phase_next = PH_HDR0;
                end
                default:
                begin
                    fin_next    = stream_byte[7];
                    opcode_next = stream_byte[3:0];
                    count_next  = '0;
                    phase_next  = PH_HDR1;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push            = 1'b0;
        push_cmd.data   = '0;
        push_cmd.key    = '0;
        push_cmd.opcode = opcode_reg;
        push_cmd.fin    = fin_reg;
        push_cmd.empty  = 1'b1;
        push_cmd.last   = 1'b1;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR1:
                    push = (len7 != LEN_EXT16) && (len7 != LEN_EXT64)
                        && !stream_byte[7] && (len7 == 7'd0);
                PH_EXT:
                    push = (count_dec == 4'd0) && !masked_reg && (ext_len == 64'd0);
                PH_KEY:
                    push = (count_dec == 4'd0) && (remain_reg == 64'd0);
                PH_DATA:
                begin
                    push           = 1'b1;
                    push_cmd.data  = stream_byte;
                    push_cmd.key   = masked_reg ? key_byte : 8'd0;
                    push_cmd.empty = 1'b0;
                    push_cmd.last  = data_last;
                end
                default:
                    push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            count_reg  <= '0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            remain_reg <= '0;
            key_reg    <= '0;
            index_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            remain_reg <= remain_next;
            key_reg    <= key_next;
            index_reg  <= index_next;
        end
    end

endmodule

// ===== sv/wsd_queue.sv =====
// ----------------------------------------------------------------------------
// wsd_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module wsd_queue
    import wsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cmd_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == FULL_COUNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/wsd_output.sv =====
// ----------------------------------------------------------------------------
// wsd_output
// Back end: unmasks the queued item and holds it in the output register.
// ----------------------------------------------------------------------------
module wsd_output
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] payload_byte,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       empty_frame,
    output logic       frame_end
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [3:0] opcode_reg;
    logic       fin_reg;
    logic       empty_reg;
    logic       last_reg;

    assign pop = head_valid && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= head_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg   <= head_cmd.data ^ head_cmd.key;
            opcode_reg <= head_cmd.opcode;
            fin_reg    <= head_cmd.fin;
            empty_reg  <= head_cmd.empty;
            last_reg   <= head_cmd.last;
        end
    end

    assign out_valid      = valid_reg;
    assign payload_byte   = byte_reg;
    assign frame_opcode   = opcode_reg;
    assign final_fragment = fin_reg;
    assign empty_frame    = empty_reg;
    assign frame_end      = last_reg;

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame deframer: one stream byte in, unmasked payload bytes out.
// ----------------------------------------------------------------------------
// usage
//   input channel: stream_byte with in_valid / in_stall, one byte per item
//   output channel: payload_byte, frame_opcode, final_fragment, empty_frame,
//   frame_end with out_valid / out_stall
//   header, length and mask key bytes give no result; each payload byte gives
//   one, and a zero-length frame gives a single empty_frame item
//   a result passes through a queue slot and then the output register
//   throughput: one byte per cycle while in_stall is low, set by the header parser
//   a QUEUE_DEPTH entry queue sits between parser and output register;
//   in_stall rises only while that queue is full, so a stalled receiver
//   backs up into the input after QUEUE_DEPTH + 1 results
//   reset clears parser state, queue and output valid; the parser then waits
//   for byte 0 of a new frame
// ----------------------------------------------------------------------------
module websocket_frame_deframer
    import wsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] stream_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       empty_frame,
    output logic       frame_end
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic full;
    logic head_valid;
    cmd_t head_cmd;

    assign in_stall = full;
    assign accept   = in_valid && !in_stall;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wsd_output u_output (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .empty_frame    (empty_frame),
        .frame_end      (frame_end)
    );

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("item pushed into full queue");

    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_frame |-> frame_end && (payload_byte == 8'd0))
        else $error("empty frame item not marked as frame end with zero byte");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("item pushed without accepted byte");
`endif

endmodule

// ===== tb/sv/deframe_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches both channels of the frame deframer. Every byte taken on the input
// runs through a local copy of the header parser and unmasker. That yields
// the payload items expected on the output, in order. Each item taken on the
// output is checked field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module deframe_checker
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] stream_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] payload_byte,
    input  logic [3:0] frame_opcode,
    input  logic       final_fragment,
    input  logic       empty_frame,
    input  logic       frame_end,
    output int         mismatch_count,
    output int         pending_count
);

    typedef struct packed {
        logic [7:0] payload;
        logic [3:0] opcode;
        logic       fin;
        logic       empty;
        logic       last;
    } frame_result_t;

    frame_result_t expected_payload_q[$];
    int            errors;

    phase_t      phase;
    logic [3:0]  hdr_left;
    logic [3:0]  held_opcode;
    logic        held_fin;
    logic        held_masked;
    logic [63:0] remaining;
    logic [31:0] mask_key;
    logic [1:0]  lane;

    task automatic push_result(input logic [7:0] data, input logic empty, input logic last);
        frame_result_t r;
        r.payload = data;
        r.opcode  = held_opcode;
        r.fin     = held_fin;
        r.empty   = empty;
        r.last    = last;
        expected_payload_q.insert(expected_payload_q.size(), r);
    endtask

    // length and key are in place
    task automatic start_payload();
        lane = 2'd0;
        if (remaining == 64'd0)
        begin
            phase = PH_HDR0;
            push_result(8'h00, 1'b1, 1'b1);
        end
        else
        begin
            phase = PH_DATA;
        end
    endtask

    task automatic length_known();
        if (held_masked)
        begin
            phase    = PH_KEY;
            hdr_left = KEY_BYTES;
            mask_key = 32'd0;
        end
        else
        begin
            start_payload();
        end
    endtask

    task automatic take_stream_byte(input logic [7:0] b);
        logic [7:0] k;
        case (phase)
            PH_HDR1:
            begin
                held_masked = b[7];
                remaining   = 64'd0;
                if (b[6:0] == LEN_EXT16)
                begin
                    phase    = PH_EXT;
                    hdr_left = EXT16_BYTES;
                end
                else if (b[6:0] == LEN_EXT64)
                begin
                    phase    = PH_EXT;
                    hdr_left = EXT64_BYTES;
                end
                else
                begin
                    remaining = 64'(b[6:0]);
                    length_known();
                end
            end
            PH_EXT:
            begin
                remaining = {remaining[55:0], b};
                hdr_left  = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    length_known();
            end
            PH_KEY:
            begin
                mask_key = {mask_key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    start_payload();
            end
            PH_DATA:
            begin
                k = held_masked ? 8'(mask_key >> (5'd24 - {lane, 3'b000})) : 8'h00;
                lane      = lane + 2'd1;
                remaining = remaining - 64'd1;
                if (remaining == 64'd0)
                    phase = PH_HDR0;
                push_result(b ^ k, 1'b0, remaining == 64'd0);
            end
            default:
            begin
                held_fin    = b[7];
                held_opcode = b[3:0];
                hdr_left    = 4'd0;
                phase       = PH_HDR1;
            end
        endcase
    endtask

    task automatic check_result();
        frame_result_t e;
        if (expected_payload_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected item: byte %02h op %h fin %b empty %b end %b",
                         payload_byte, frame_opcode, final_fragment, empty_frame, frame_end);
        end
        else
        begin
            e = expected_payload_q.pop_front();
            if (e.payload !== payload_byte || e.opcode !== frame_opcode
                || e.fin !== final_fragment || e.empty !== empty_frame
                || e.last !== frame_end)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %02h %h %b %b %b, got %02h %h %b %b %b",
                             e.payload, e.opcode, e.fin, e.empty, e.last,
                             payload_byte, frame_opcode, final_fragment, empty_frame,
                             frame_end);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase          = PH_HDR0;
            hdr_left       = 4'd0;
            held_opcode    = 4'd0;
            held_fin       = 1'b0;
            held_masked    = 1'b0;
            remaining      = 64'd0;
            mask_key       = 32'd0;
            lane           = 2'd0;
            errors         = 0;
            expected_payload_q.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                take_stream_byte(stream_byte);
            mismatch_count <= errors;
            pending_count  <= expected_payload_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the frame deframer. A short directed run comes
// first: an empty frame, unmasked and masked payloads and a zero extended
// length after a key. Random frames follow, with every header form and
// random opcodes, flags, keys and data. The last frame carries a 64-bit
// length with its top bit set. The sender bursts and the receiver stalls on
// shifting patterns. One long receiver hold-off backs the block up, and one
// sender pause lets every result drain. The checker reports mismatches.
// ----------------------------------------------------------------------------
module tb_top
    import wsd_pkg::*;
();

    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {HDR_LEN7, HDR_LEN16, HDR_LEN64} len_form_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] stream_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       empty_frame;
    logic       frame_end;

    int   mismatch_count;
    int   pending_count;
    int   cycle_count = 0;
    int   items_sent = 0;
    int   burst_left = 0;
    logic hold_req = 1'b0;

    websocket_frame_deframer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .empty_frame    (empty_frame),
        .frame_end      (frame_end)
    );

    deframe_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .empty_frame    (empty_frame),
        .frame_end      (frame_end),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("websocket_frame_deframer test failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                              input len_form_t form, input logic [63:0] len,
                              input int payload_count);
        logic [31:0] mkey;
        mkey = $urandom;
        send_byte(hdr0);
        case (form)
            HDR_LEN7:
                send_byte({masked, len[6:0]});
            HDR_LEN16:
            begin
                send_byte({masked, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                send_byte(mkey[8*i +: 8]);
        for (int i = 0; i < payload_count; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // receiver stall patterns, with one long hold-off on request
    initial
    begin
        int  mode;
        int  seg;
        bit  hold_done;
        hold_done = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(5, 60);
            for (int k = 0; k < seg; k++)
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= (k % 4 == 3);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        len_form_t   form;
        logic [63:0] len;
        logic [63:0] huge_len;
        int          pick;
        bit          paused;
        paused = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frame with a 7-bit zero length
        send_byte(8'h81);
        send_byte(8'h00);
        // unmasked, fin clear, reserved bits set
        send_byte(8'h72);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        // masked, all key lanes plus a wrap
        send_byte(8'hF8);
        send_byte(8'h85);
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'hFF);
        // 16-bit zero length with a key, empty item after the key
        send_byte(8'h0F);
        send_byte(8'hFE);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS / 2)
                hold_req = 1'b1;
            if (!paused && items_sent >= 3 * RANDOM_ITEMS / 4)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                form = HDR_LEN7;
                if ($urandom_range(0, 9) == 0)
                    len = 64'd0;
                else if ($urandom_range(0, 19) == 0)
                    len = 64'($urandom_range(13, 125));
                else
                    len = 64'($urandom_range(1, 12));
            end
            else if (pick < 8)
            begin
                form = HDR_LEN16;
                if ($urandom_range(0, 7) == 0)
                    len = 64'd0;
                else if ($urandom_range(0, 9) == 0)
                    len = 64'($urandom_range(126, 300));
                else
                    len = 64'($urandom_range(1, 16));
            end
            else
            begin
                form = HDR_LEN64;
                len  = ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom_range(1, 16));
            end
            send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len,
                       int'(len));
        end

        // 64-bit length with the top bit set, never completes
        huge_len = {1'b1, 31'($urandom), 32'($urandom)};
        send_frame(8'($urandom_range(0, 255)), 1'b1, HDR_LEN64, huge_len, 40);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("websocket_frame_deframer test passed");
        else
            $display("websocket_frame_deframer test failed");
        $finish;
    end

endmodule
